>>> sv/multichannel_envelope_follower_macros.svh
// ----------------------------------------------------------------------------
// Envelope follower assertion macros
// Shared property shorthands for the envelope follower checkers.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_ENVELOPE_FOLLOWER_MACROS_SVH
`define MULTICHANNEL_ENVELOPE_FOLLOWER_MACROS_SVH

// Generic clocked assertion, disabled while reset is held.
`define MEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A beat that is offered and not taken is still offered, unchanged, next cycle.
`define MEF_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

>>> sv/mef_pkg.sv
// ----------------------------------------------------------------------------
// Envelope follower package
// Widths, constants, register codes and shared types of the envelope follower.
// ----------------------------------------------------------------------------
`default_nettype none

package mef_pkg;

  // Geometry of the block.
  localparam int MAX_CHANNELS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int FIFO_DEPTH    = 2;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int CH_W      = 3;
  localparam int CNT_W     = 4;
  localparam int ALPHA_W   = 16;
  localparam int ENV_W     = 19;
  localparam int MAG_W     = SAMPLE_W;
  localparam int LEVEL_W   = ENV_W + FRACTION_BITS;
  localparam int CH_IDX_W  = $clog2(MAX_CHANNELS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = ALPHA_W;

  // Reset values of the configuration registers.
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(65388);
  localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(2);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_COUNT   = 2'd2
  } mef_cfg_idx_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [ALPHA_W-1:0] attack_alpha;
    logic [ALPHA_W-1:0] release_alpha;
    logic [CNT_W-1:0]   channel_count;
  } mef_cfg_t;

  // Classified work item passed from the front end to the level update.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [CH_W-1:0]  ch;
    logic             last;
  } mef_item_t;

endpackage

`default_nettype wire

>>> sv/mef_in_if.sv
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one audio sample and its channel index.
// ----------------------------------------------------------------------------
`default_nettype none

interface mef_in_if
  import mef_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic        [CH_W-1:0]     channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

`default_nettype wire

>>> sv/mef_out_if.sv
// ----------------------------------------------------------------------------
// Envelope output channel
// Valid/ready channel carrying the integer peak envelope of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface mef_out_if
  import mef_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ENV_W-1:0] envelope;

  modport source (output valid, output envelope, input ready);
  modport sink   (input valid, input envelope, output ready);
endinterface

`default_nettype wire

>>> sv/mef_front.sv
// ----------------------------------------------------------------------------
// Envelope follower front end
// Accepts sample beats, drops inactive channels, takes the magnitude and
// marks the frame's last channel, then registers the item for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_front
  import mef_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  mef_in_if.sink         in_if,
  input  wire mef_cfg_t  cfg_i,
  output logic           item_valid_o,
  output mef_item_t      item_o,
  input  wire logic      item_ready_i
);

  logic [CNT_W-1:0] active;
  logic             in_fire;
  logic             in_active;
  mef_item_t        item_new;
  logic             valid_d, valid_q;
  mef_item_t        item_d, item_q;

  // Effective channel count, clamped to the number of channel slots.
  assign active = (cfg_i.channel_count > CNT_W'(MAX_CHANNELS)) ?
                  CNT_W'(MAX_CHANNELS) : cfg_i.channel_count;

  // Classify the incoming beat.
  always_comb begin
    in_active     = ({{(CNT_W-CH_W){1'b0}}, in_if.channel} < active);
    item_new.mag  = in_if.sample[SAMPLE_W-1] ? MAG_W'(~in_if.sample + 1'b1) :
                                               MAG_W'(in_if.sample);
    item_new.ch   = in_if.channel;
    item_new.last = ({{(CNT_W-CH_W){1'b0}}, in_if.channel} == (active - 1'b1));
  end

  // The stage takes a beat whenever its register is empty or draining.
  assign in_if.ready = !valid_q || item_ready_i;
  assign in_fire     = in_if.valid && in_if.ready;

  // Pipeline register; beats on inactive channels are taken and dropped.
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_fire) begin
      valid_d = in_active;
      item_d  = item_new;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

>>> sv/mef_fifo.sv
// ----------------------------------------------------------------------------
// Envelope follower item queue
// Short register queue between the front end and the level update.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_fifo
  import mef_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mef_item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  output mef_item_t      item_o,
  input  wire logic      pop_i
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_QW = $clog2(FIFO_DEPTH + 1);

  mef_item_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_d, wr_ptr_q;
  logic [PTR_W-1:0]    rd_ptr_d, rd_ptr_q;
  logic [CNT_QW-1:0]   count_d, count_q;
  logic                do_push;
  logic                do_pop;

  // A full queue still takes a beat in the cycle it hands one on.
  assign valid_o = (count_q != '0);
  assign ready_o = (count_q != CNT_QW'(FIFO_DEPTH)) || pop_i;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/mef_back.sv
// ----------------------------------------------------------------------------
// Envelope follower level update
// Runs the per-channel attack/release filter, tracks the frame peak and
// holds the frame result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_back
  import mef_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      item_valid_i,
  input  wire mef_item_t item_i,
  output logic           pop_o,
  input  wire mef_cfg_t  cfg_i,
  mef_out_if.source      out_if
);

  localparam int PRODL_W = ALPHA_W + LEVEL_W;
  localparam int PRODT_W = ALPHA_W + 1 + ENV_W;
  localparam int ACC_W   = ALPHA_W + LEVEL_W + 1;
  localparam logic [ALPHA_W:0] ALPHA_ONE = (ALPHA_W + 1)'(1) << ALPHA_W;

  logic [LEVEL_W-1:0] level_q [MAX_CHANNELS];
  logic [LEVEL_W-1:0] peak_d, peak_q;
  logic               out_valid_d, out_valid_q;
  logic [ENV_W-1:0]   env_d, env_q;

  logic [LEVEL_W-1:0] level;
  logic               attack;
  logic [ALPHA_W-1:0] alpha;
  logic [ALPHA_W:0]   one_minus;
  logic [ENV_W-1:0]   ten_mag;
  logic [PRODL_W-1:0] prod_level;
  logic [PRODT_W-1:0] prod_target;
  logic [ACC_W-1:0]   acc;
  logic [LEVEL_W-1:0] level_next;

  // Take an item unless it closes a frame and the result slot is still full.
  assign pop_o = item_valid_i && (!item_i.last || !out_valid_q || out_if.ready);

  // One-pole filter: (a*level + (1-a)*(10*mag << frac)) >> 16.
  always_comb begin
    level       = level_q[item_i.ch[CH_IDX_W-1:0]];
    attack      = (LEVEL_W'({item_i.mag, {FRACTION_BITS{1'b0}}}) > level);
    alpha       = attack ? cfg_i.attack_alpha : cfg_i.release_alpha;
    one_minus   = ALPHA_ONE - {1'b0, alpha};
    ten_mag     = ENV_W'({item_i.mag, 3'b000}) + ENV_W'({item_i.mag, 1'b0});
    prod_level  = alpha * level;
    prod_target = one_minus * ten_mag;
    acc         = ACC_W'(prod_level) + ACC_W'({prod_target, {FRACTION_BITS{1'b0}}});
    level_next  = LEVEL_W'(acc >> ALPHA_W);
  end

  // Frame peak and result register.
  always_comb begin
    peak_d      = peak_q;
    out_valid_d = out_valid_q && !out_if.ready;
    env_d       = env_q;
    if (pop_o) begin
      if ((item_i.ch == '0) || (level_next > peak_q)) begin
        peak_d = level_next;
      end
      if (item_i.last) begin
        out_valid_d = 1'b1;
        env_d       = ENV_W'(peak_d >> FRACTION_BITS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        level_q[i] <= '0;
      end
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        level_q[item_i.ch[CH_IDX_W-1:0]] <= level_next;
      end
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    env_q <= env_d;
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.envelope = env_q;

endmodule

`default_nettype wire

>>> sv/multichannel_envelope_follower.sv
// ----------------------------------------------------------------------------
// Multichannel envelope follower
// Per-channel attack/release envelopes over interleaved frames; emits the
// integer peak envelope of each frame on its last active channel.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload                   Beat
//   in_if     in         sample (16 s), channel(3) one sample of one channel
//   out_if    out        envelope (19 u)           one frame peak
//   cfg       in         cfg_idx_i, cfg_data_i     one register write
//
// One sample is accepted every cycle while the stages behind have room; a
// frame result passes the front register, queue and result register. The
// level update sets the rate; it reads, filters and writes a channel envelope.
// Reset clears all channel envelopes and the frame peak at once.
// A waiting result stalls only items that close a frame; the queue and
// front register keep taking samples until they fill up behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_envelope_follower
  import mef_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  mef_in_if.sink                    in_if,
  mef_out_if.source                 out_if,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  mef_cfg_t  cfg_d, cfg_q;
  logic      front_valid;
  mef_item_t front_item;
  logic      fifo_ready;
  logic      fifo_valid;
  mef_item_t fifo_item;
  logic      back_pop;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTACK:  cfg_d.attack_alpha  = cfg_data_i[ALPHA_W-1:0];
        CFG_RELEASE: cfg_d.release_alpha = cfg_data_i[ALPHA_W-1:0];
        CFG_COUNT:   cfg_d.channel_count = cfg_data_i[CNT_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_alpha  <= ALPHA_RST;
      cfg_q.release_alpha <= ALPHA_RST;
      cfg_q.channel_count <= COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accept and classify.
  mef_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_i        (cfg_q),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (fifo_ready)
  );

  // Decoupling queue.
  mef_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .item_i  (front_item),
    .ready_o (fifo_ready),
    .valid_o (fifo_valid),
    .item_o  (fifo_item),
    .pop_i   (back_pop)
  );

  // Back end: envelope update and frame result.
  mef_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (fifo_valid),
    .item_i       (fifo_item),
    .pop_o        (back_pop),
    .cfg_i        (cfg_q),
    .out_if       (out_if)
  );

endmodule

`default_nettype wire

>>> sv/mef_checker.sv
// ----------------------------------------------------------------------------
// Envelope follower port checker
// Port-level properties of the envelope follower, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_envelope_follower_macros.svh"

module mef_checker
  import mef_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ENV_W-1:0] envelope
);

  localparam logic [ENV_W-1:0] ENV_MAX = ENV_W'(327680);

  // A waiting result holds until the sink takes it.
  `MEF_ASSERT_HOLD(a_out_hold, out_valid, out_ready, envelope, "result changed while stalled")

  // The envelope never exceeds ten times full scale.
  `MEF_ASSERT(a_env_range, out_valid |-> (envelope <= ENV_MAX), "envelope out of range")

  // Samples are only held back while a frame result waits.
  `MEF_ASSERT(a_in_free, !out_valid |-> in_ready, "input stalled with no result pending")

  // A stalled result cannot vanish unless it was taken.
  `MEF_ASSERT(a_out_kept, (out_valid && !out_ready) |=> out_valid, "result dropped")

endmodule

bind multichannel_envelope_follower mef_checker u_mef_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .envelope  (out_if.envelope)
);

`default_nettype wire
